FILE: src/qcc_pkg.sv
// Package with the shared widths, reset values and codes of the quadrature counter.
`timescale 1ns / 1ps
`default_nettype none

package qcc_pkg;

    // Default sizing of the counter bank.
    localparam int QCC_NUM_CHANNELS = 6;
    localparam int QCC_COUNT_WIDTH  = 32;

    // Fixed field widths of the item channels.
    localparam int PIN_W      = 6;
    localparam int SENSOR_W   = 4;
    localparam int INDEX_W    = 5;
    localparam int DATA_W     = 32;
    localparam int EVENT_W    = 8;
    localparam int DELAY_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_CAPT   = 5;
    localparam int NUM_EVENTS = 7;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK  = 2'd1;
    localparam logic [DELAY_W-1:0]   CAPTURE_DELAY_RST = 8'd32;
    localparam logic [PIN_W-1:0]     REVERSE_MASK_RST  = 6'd2;

    // Item action codes.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Channels that feed the captures.
    localparam int CH_WRIST   = 0;
    localparam int CH_ANGLE   = 2;
    localparam int CH_INDEXER = 3;

    // Sensor bits.
    localparam int SNS_TOP    = 0;
    localparam int SNS_BOTTOM = 1;
    localparam int SNS_WRIST  = 2;
    localparam int SNS_ANGLE  = 3;

    // Capture slots.
    localparam int CAP_TOP_RISE = 0;
    localparam int CAP_TOP_FALL = 1;
    localparam int CAP_DELAYED  = 2;
    localparam int CAP_WRIST    = 3;
    localparam int CAP_ANGLE    = 4;

    // Event count slots.
    localparam int EV_TOP_RISE    = 0;
    localparam int EV_TOP_FALL    = 1;
    localparam int EV_BOTTOM_RISE = 2;
    localparam int EV_BOTTOM_FALL = 3;
    localparam int EV_DELAYED     = 4;
    localparam int EV_WRIST       = 5;
    localparam int EV_ANGLE       = 6;

    // Read map.
    localparam logic [INDEX_W-1:0] RD_COUNT_LAST  = 5'd5;
    localparam logic [INDEX_W-1:0] RD_CAPT_FIRST  = 5'd6;
    localparam logic [INDEX_W-1:0] RD_CAPT_LAST   = 5'd10;
    localparam logic [INDEX_W-1:0] RD_EVENT_FIRST = 5'd11;
    localparam logic [INDEX_W-1:0] RD_EVENT_LAST  = 5'd17;
    localparam logic [INDEX_W-1:0] RD_LEVELS      = 5'd18;
    localparam logic [INDEX_W-1:0] RD_ERRORS      = 5'd19;
    localparam logic [DATA_W-1:0]  RD_INVALID     = '1;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [INDEX_W-1:0] read_echo;
    } t_result;

endpackage

`default_nettype wire

FILE: src/qcc_if.sv
// Handshake interfaces for the tick/read items, the read results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface qcc_in_if import qcc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [PIN_W-1:0]    enc_a;
    logic [PIN_W-1:0]    enc_b;
    logic [SENSOR_W-1:0] sensor_levels;
    logic                ms_strobe;
    logic [INDEX_W-1:0]  read_index;

    modport source (output valid, action, enc_a, enc_b, sensor_levels, ms_strobe,
                    read_index, input ready);
    modport sink   (input valid, action, enc_a, enc_b, sensor_levels, ms_strobe,
                    read_index, output ready);
endinterface

interface qcc_out_if import qcc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  read_data;
    logic [INDEX_W-1:0]        read_echo;

    modport source (output valid, read_data, read_echo, input ready);
    modport sink   (input valid, read_data, read_echo, output ready);
endinterface

interface qcc_cfg_if import qcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/quadrature_counter_with_captures_top.sv
// Top level of the x4 quadrature counter bank with sensor event captures.
//
//  Channel  Port    Dir  Carries
//  -------  ------  ---  ---------------------------------------------------
//  items    i_in    in   action, enc_a, enc_b, sensor_levels, ms_strobe, read_index
//  results  o_out   out  read_data, read_echo (one per read item)
//  config   i_cfg   in   index, data (0 capture_delay_ms, 1 reverse_mask)
//
// A tick updates all counters, captures and the delay countdown when it is
// accepted, and a read loads its result into the output buffer.
// A two-entry output buffer (result register plus skid register) keeps i_in
// ready while one result waits; i_in only stalls once both entries are full.
// Synchronous reset clears all state but the result data and restores the configuration defaults.
// The configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_counter_with_captures_top
    import qcc_pkg::*;
#(
    parameter int NUM_CHANNELS = QCC_NUM_CHANNELS,
    parameter int COUNT_WIDTH  = QCC_COUNT_WIDTH
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    qcc_in_if.sink      i_in,
    qcc_out_if.source   o_out,
    qcc_cfg_if.sink     i_cfg
);

    // Only the six pin bits can ever move a counter, so channels beyond the
    // pin field are never built: they would stay at zero and are not readable.
    localparam int NCH = (NUM_CHANNELS < PIN_W) ? NUM_CHANNELS : PIN_W;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // Configuration registers.
    logic [DELAY_W-1:0] r_cfg_delay;
    logic [PIN_W-1:0]   r_reverse;

    // Counter state.
    t_count             r_count [NCH];
    t_count             n_count [NCH];
    logic [NCH-1:0]     r_last_a, r_last_b, n_err, r_err;
    logic [SENSOR_W-1:0] r_last_s;
    t_count             r_capt  [NUM_CAPT];
    t_count             n_capt  [NUM_CAPT];
    logic [EVENT_W-1:0] r_event [NUM_EVENTS];
    logic [EVENT_W-1:0] n_event [NUM_EVENTS];
    logic [DELAY_W-1:0] r_delay_rem, n_delay_rem;
    logic               r_armed, n_armed;

    // Output buffer.
    t_result r_out, r_skid, n_out, n_skid, rd_result;
    logic    r_out_valid, r_skid_valid, n_out_valid, n_skid_valid;

    logic                in_acc, tick_acc, rd_acc, out_take;
    logic [NCH-1:0]      pin_a, pin_b;
    logic [SENSOR_W-1:0] rise, fall;
    t_count              indexer_val, wrist_val, angle_val;

    assign i_in.ready  = !r_skid_valid;
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign tick_acc    = in_acc && (i_in.action == ACT_TICK);
    assign rd_acc      = in_acc && (i_in.action == ACT_READ);
    assign out_take    = r_out_valid && o_out.ready;

    assign pin_a = i_in.enc_a[NCH-1:0];
    assign pin_b = i_in.enc_b[NCH-1:0];
    assign rise  = i_in.sensor_levels & ~r_last_s;
    assign fall  = r_last_s & ~i_in.sensor_levels;

    // Per-channel x4 decode. A change on one pin steps the counter; a change
    // on both pins at once cannot be decoded and only flags the channel.
    always_comb begin
        logic da, db, up;
        n_err = r_err;
        for (int ch = 0; ch < NCH; ch++) begin
            da = pin_a[ch] ^ r_last_a[ch];
            db = pin_b[ch] ^ r_last_b[ch];
            up = (da ? (pin_a[ch] == pin_b[ch]) : (pin_a[ch] != pin_b[ch])) ^ r_reverse[ch];
            n_count[ch] = r_count[ch];
            if (da && db) begin
                n_err[ch] = 1'b1;
            end else if (da || db) begin
                n_count[ch] = up ? r_count[ch] + 1'b1 : r_count[ch] - 1'b1;
            end
        end
    end

    // Captures see the counters as updated by the same tick.
    always_comb begin
        indexer_val = '0;
        angle_val   = '0;
        wrist_val   = n_count[CH_WRIST];
        for (int ch = 0; ch < NCH; ch++) begin
            if (ch == CH_INDEXER) begin
                indexer_val = n_count[ch];
            end
            if (ch == CH_ANGLE) begin
                angle_val = n_count[ch];
            end
        end
    end

    // Sensor events and the delayed capture after the bottom sensor releases.
    always_comb begin
        n_capt      = r_capt;
        n_event     = r_event;
        n_delay_rem = r_delay_rem;
        n_armed     = r_armed;
        if (rise[SNS_TOP]) begin
            n_event[EV_TOP_RISE] = r_event[EV_TOP_RISE] + 1'b1;
            n_capt[CAP_TOP_RISE] = indexer_val;
        end
        if (fall[SNS_TOP]) begin
            n_event[EV_TOP_FALL] = r_event[EV_TOP_FALL] + 1'b1;
            n_capt[CAP_TOP_FALL] = indexer_val;
        end
        if (rise[SNS_BOTTOM]) begin
            n_event[EV_BOTTOM_RISE] = r_event[EV_BOTTOM_RISE] + 1'b1;
        end
        if (r_armed && i_in.ms_strobe && (r_delay_rem != '0)) begin
            n_delay_rem = r_delay_rem - 1'b1;
        end
        // A release while armed restarts the countdown from the full delay.
        if (fall[SNS_BOTTOM]) begin
            n_event[EV_BOTTOM_FALL] = r_event[EV_BOTTOM_FALL] + 1'b1;
            n_armed     = 1'b1;
            n_delay_rem = r_cfg_delay;
        end
        if (rise[SNS_WRIST]) begin
            n_event[EV_WRIST] = r_event[EV_WRIST] + 1'b1;
            n_capt[CAP_WRIST] = wrist_val;
        end
        if (rise[SNS_ANGLE]) begin
            n_event[EV_ANGLE] = r_event[EV_ANGLE] + 1'b1;
            n_capt[CAP_ANGLE] = angle_val;
        end
        // Expiry is checked after the reload, so a zero delay fires at once.
        if (n_armed && (n_delay_rem == '0)) begin
            n_capt[CAP_DELAYED]  = indexer_val;
            n_event[EV_DELAYED]  = n_event[EV_DELAYED] + 1'b1;
            n_armed              = 1'b0;
        end
    end

    // Register read decode.
    always_comb begin
        logic [INDEX_W-1:0] idx;
        idx = i_in.read_index;
        rd_result.read_echo = idx;
        rd_result.read_data = RD_INVALID;
        if (idx <= RD_COUNT_LAST) begin
            for (int ch = 0; ch < NCH; ch++) begin
                if (idx == INDEX_W'(ch)) begin
                    rd_result.read_data = DATA_W'($signed(r_count[ch]));
                end
            end
        end else if (idx <= RD_CAPT_LAST) begin
            rd_result.read_data = DATA_W'($signed(r_capt[3'(idx - RD_CAPT_FIRST)]));
        end else if (idx <= RD_EVENT_LAST) begin
            rd_result.read_data = DATA_W'(r_event[3'(idx - RD_EVENT_FIRST)]);
        end else if (idx == RD_LEVELS) begin
            rd_result.read_data = DATA_W'(r_last_s);
        end else if (idx == RD_ERRORS) begin
            rd_result.read_data = DATA_W'(r_err);
        end
    end

    // Output register with a skid entry behind it.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = rd_result;
                n_out_valid = rd_acc;
            end
        end else if (rd_acc) begin
            if (r_out_valid) begin
                n_skid       = rd_result;
                n_skid_valid = 1'b1;
            end else begin
                n_out       = rd_result;
                n_out_valid = 1'b1;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out.read_data;
    assign o_out.read_echo = r_out.read_echo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_delay  <= CAPTURE_DELAY_RST;
            r_reverse    <= REVERSE_MASK_RST;
            r_last_a     <= '0;
            r_last_b     <= '0;
            r_last_s     <= '0;
            r_err        <= '0;
            r_delay_rem  <= '0;
            r_armed      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            for (int ch = 0; ch < NCH; ch++) begin
                r_count[ch] <= '0;
            end
            for (int k = 0; k < NUM_CAPT; k++) begin
                r_capt[k] <= '0;
            end
            for (int k = 0; k < NUM_EVENTS; k++) begin
                r_event[k] <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_CAPTURE_DELAY: r_cfg_delay <= i_cfg.data[DELAY_W-1:0];
                    REG_REVERSE_MASK:  r_reverse   <= i_cfg.data[PIN_W-1:0];
                    default: ;
                endcase
            end
            if (tick_acc) begin
                r_count     <= n_count;
                r_err       <= n_err;
                r_last_a    <= pin_a;
                r_last_b    <= pin_b;
                r_last_s    <= i_in.sensor_levels;
                r_capt      <= n_capt;
                r_event     <= n_event;
                r_delay_rem <= n_delay_rem;
                r_armed     <= n_armed;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // The delayed capture fires in the same tick that the countdown reaches zero.
    a_no_idle_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_armed && (r_delay_rem == '0)))
        else $error("delay armed with nothing left to count");

    // The skid entry is only used behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result without the output register");

    // Error flags are sticky until reset.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_err & $past(r_err)) == $past(r_err)))
        else $error("quadrature error flag cleared");

    // A read never disturbs the counter state.
    a_read_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.action == ACT_READ)) |=> $stable(r_last_s) && $stable(r_err))
        else $error("read item changed counter state");

endmodule

`default_nettype wire

FILE: tb/quadrature_counter_with_captures_top_tb.sv
// Self-checking testbench for the quadrature counter bank with sensor captures.
`timescale 1ns / 1ps

module quadrature_counter_with_captures_top_tb;
    import qcc_pkg::*;

    // Codes that the package leaves unnamed but the stimulus needs.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED   = 2'd3;
    localparam logic [INDEX_W-1:0]   RD_COUNT_FIRST = 5'd0;
    localparam logic [INDEX_W-1:0]   RD_UNMAPPED    = 5'd20;
    localparam logic [INDEX_W-1:0]   RD_INDEX_TOP   = 5'd31;
    localparam int                   NCH            = QCC_NUM_CHANNELS;

    // One item as it crosses the input channel.
    typedef struct packed {
        logic                action;
        logic [PIN_W-1:0]    enc_a;
        logic [PIN_W-1:0]    enc_b;
        logic [SENSOR_W-1:0] sensors;
        logic                strobe;
        logic [INDEX_W-1:0]  read_index;
    } t_pin_item;

    // Tracks the counter bank from the accepted items and checks every read result
    // against the oldest pending read.
    class t_capture_scoreboard;
        logic [DELAY_W-1:0]         delay_cfg;
        logic [PIN_W-1:0]           reverse_cfg;
        logic [QCC_COUNT_WIDTH-1:0] counts [NCH];
        logic [DATA_W-1:0]          captures [NUM_CAPT];
        logic [EVENT_W-1:0]         events [NUM_EVENTS];
        logic [PIN_W-1:0]           prev_a;
        logic [PIN_W-1:0]           prev_b;
        logic [PIN_W-1:0]           err_bits;
        logic [SENSOR_W-1:0]        prev_s;
        logic [DELAY_W-1:0]         remaining;
        bit                         armed;
        t_result                    expected_reads [$];
        int unsigned                failures;
        int unsigned                reads_checked;
        int unsigned                ticks_seen;
        int unsigned                delayed_fired;

        function new();
            delay_cfg   = CAPTURE_DELAY_RST;
            reverse_cfg = REVERSE_MASK_RST;
            foreach (counts[i]) counts[i] = '0;
            foreach (captures[i]) captures[i] = '0;
            foreach (events[i]) events[i] = '0;
            prev_a        = '0;
            prev_b        = '0;
            err_bits      = '0;
            prev_s        = '0;
            remaining     = '0;
            armed         = 1'b0;
            failures      = 0;
            reads_checked = 0;
            ticks_seen    = 0;
            delayed_fired = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_CAPTURE_DELAY) begin
                delay_cfg = val;
            end else if (idx == REG_REVERSE_MASK) begin
                reverse_cfg = val[PIN_W-1:0];
            end
        endfunction

        function t_result lookup(logic [INDEX_W-1:0] idx);
            t_result r;
            r.read_echo = idx;
            if (idx <= RD_COUNT_LAST) begin
                r.read_data = counts[3'(idx)];
            end else if (idx <= RD_CAPT_LAST) begin
                r.read_data = captures[3'(idx - RD_CAPT_FIRST)];
            end else if (idx <= RD_EVENT_LAST) begin
                r.read_data = DATA_W'(events[3'(idx - RD_EVENT_FIRST)]);
            end else if (idx == RD_LEVELS) begin
                r.read_data = DATA_W'(prev_s);
            end else if (idx == RD_ERRORS) begin
                r.read_data = DATA_W'(err_bits);
            end else begin
                r.read_data = RD_INVALID;
            end
            return r;
        endfunction

        function void note_item(t_pin_item it);
            logic [SENSOR_W-1:0] rise;
            logic [SENSOR_W-1:0] fall;
            bit                  da;
            bit                  db;
            bit                  up;
            if (it.action == ACT_READ) begin
                expected_reads.push_back(lookup(it.read_index));
                return;
            end
            ticks_seen++;
            // Counters move first so that captures on this tick see the new values.
            for (int ch = 0; ch < NCH; ch++) begin
                da = it.enc_a[ch] ^ prev_a[ch];
                db = it.enc_b[ch] ^ prev_b[ch];
                if (da && db) begin
                    err_bits[ch] = 1'b1;
                end else if (da || db) begin
                    up = da ? (it.enc_a[ch] == it.enc_b[ch]) : (it.enc_a[ch] != it.enc_b[ch]);
                    if (reverse_cfg[ch]) up = !up;
                    counts[ch] = up ? counts[ch] + 1'b1 : counts[ch] - 1'b1;
                end
            end
            prev_a = it.enc_a;
            prev_b = it.enc_b;

            rise   = it.sensors & ~prev_s;
            fall   = prev_s & ~it.sensors;
            prev_s = it.sensors;
            if (rise[SNS_TOP]) begin
                events[EV_TOP_RISE]++;
                captures[CAP_TOP_RISE] = counts[CH_INDEXER];
            end
            if (fall[SNS_TOP]) begin
                events[EV_TOP_FALL]++;
                captures[CAP_TOP_FALL] = counts[CH_INDEXER];
            end
            if (rise[SNS_BOTTOM]) events[EV_BOTTOM_RISE]++;
            if (armed && it.strobe && remaining != 0) remaining--;
            // A bottom release restarts the delay even while one is running.
            if (fall[SNS_BOTTOM]) begin
                events[EV_BOTTOM_FALL]++;
                armed     = 1'b1;
                remaining = delay_cfg;
            end
            if (rise[SNS_WRIST]) begin
                events[EV_WRIST]++;
                captures[CAP_WRIST] = counts[CH_WRIST];
            end
            if (rise[SNS_ANGLE]) begin
                events[EV_ANGLE]++;
                captures[CAP_ANGLE] = counts[CH_ANGLE];
            end
            if (armed && remaining == 0) begin
                captures[CAP_DELAYED] = counts[CH_INDEXER];
                events[EV_DELAYED]++;
                armed = 1'b0;
                delayed_fired++;
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic [INDEX_W-1:0] echo);
            t_result want;
            if (expected_reads.size() == 0) begin
                $error("unexpected read result: read_data %0d, read_echo %0d",
                       $signed(data), echo);
                failures++;
                return;
            end
            want = expected_reads.pop_front();
            reads_checked++;
            if (data !== want.read_data) begin
                $error("read_data (index %0d): expected %0d, got %0d", want.read_echo,
                       $signed(want.read_data), $signed(data));
                failures++;
            end
            if (echo !== want.read_echo) begin
                $error("read_echo: expected %0d, got %0d", want.read_echo, echo);
                failures++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    qcc_in_if  items_if ();
    qcc_out_if reads_if ();
    qcc_cfg_if cfg_if ();

    quadrature_counter_with_captures_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (items_if.sink),
        .o_out   (reads_if.source),
        .i_cfg   (cfg_if.sink)
    );

    t_capture_scoreboard sb;

    // Idle rates of the two sides in percent, and a long hold-off of the result side.
    int send_idle_pct = 9;
    int recv_idle_pct = 48;
    int hold_off      = 0;
    int settings_used = 1;

    // Pin levels of the last tick sent, so that random ticks walk proper quadrature steps.
    logic [PIN_W-1:0]    pin_a = '0;
    logic [PIN_W-1:0]    pin_b = '0;
    logic [SENSOR_W-1:0] pin_s = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The hang guard ends the run well past the slowest legal run.
    initial begin
        #3_000_000;
        $display("[quadrature_counter_with_captures_top] ERROR");
        $finish;
    end

    // The result side changes ready at the falling edge. During a hold-off it keeps ready
    // low until the hold-off count runs out, so that the output buffer fills and the input stalls.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            reads_if.ready = 1'b0;
            hold_off--;
        end else begin
            reads_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // All handshakes are observed at the rising edge, where the driven values are stable.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
            if (items_if.valid && items_if.ready) begin
                sb.note_item('{items_if.action, items_if.enc_a, items_if.enc_b,
                               items_if.sensor_levels, items_if.ms_strobe,
                               items_if.read_index});
            end
            if (reads_if.valid && reads_if.ready) begin
                sb.check_result(reads_if.read_data, reads_if.read_echo);
            end
        end
    end

    // Offers one item, idling at random first, and returns at the falling edge after
    // the item was taken. Valid stays high so that back-to-back items need no gap.
    task automatic send_item(input t_pin_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            items_if.valid = 1'b0;
            @(negedge i_clk);
        end
        items_if.valid         = 1'b1;
        items_if.action        = it.action;
        items_if.enc_a         = it.enc_a;
        items_if.enc_b         = it.enc_b;
        items_if.sensor_levels = it.sensors;
        items_if.ms_strobe     = it.strobe;
        items_if.read_index    = it.read_index;
        do @(posedge i_clk); while (!items_if.ready);
        @(negedge i_clk);
    endtask

    // A read carries random pin fields, which the block must ignore.
    task automatic send_read(input logic [INDEX_W-1:0] idx);
        t_pin_item it;
        it.action     = ACT_READ;
        it.enc_a      = PIN_W'($urandom);
        it.enc_b      = PIN_W'($urandom);
        it.sensors    = SENSOR_W'($urandom);
        it.strobe     = 1'($urandom);
        it.read_index = idx;
        send_item(it);
    endtask

    // A tick carries a random read index, which the block must ignore.
    task automatic send_tick(input logic [PIN_W-1:0] a, input logic [PIN_W-1:0] b,
                             input logic [SENSOR_W-1:0] s, input logic strobe);
        t_pin_item it;
        pin_a         = a;
        pin_b         = b;
        pin_s         = s;
        it.action     = ACT_TICK;
        it.enc_a      = a;
        it.enc_b      = b;
        it.sensors    = s;
        it.strobe     = strobe;
        it.read_index = INDEX_W'($urandom_range(0, 31));
        send_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Stops offering items until every pending read has returned, then lets the
    // last ticks settle before anything else is done.
    task automatic wait_idle();
        items_if.valid = 1'b0;
        while (sb.expected_reads.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] delay,
                               input logic [CFG_DATA_W-1:0] mask);
        wait_idle();
        write_reg(REG_CAPTURE_DELAY, delay);
        write_reg(REG_REVERSE_MASK, mask);
        settings_used++;
    endtask

    // Random traffic. In most ticks each encoder holds or steps by one legal quadrature edge; a few
    // flip both pins of a channel or scramble all pins. Sensors toggle at random, the
    // bottom sensor at its own rate so that long delays can run out.
    task automatic run_phase(input int n_items, input int read_pct, input int bottom_div,
                             input int strobe_pct);
        logic [PIN_W-1:0]    a;
        logic [PIN_W-1:0]    b;
        logic [SENSOR_W-1:0] s;
        int                  r;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < read_pct) begin
                send_read(INDEX_W'($urandom_range(0, 31)));
            end else begin
                a = pin_a;
                b = pin_b;
                s = pin_s;
                if ($urandom_range(0, 63) == 0) begin
                    a = PIN_W'($urandom);
                    b = PIN_W'($urandom);
                end else begin
                    for (int ch = 0; ch < NCH; ch++) begin
                        r = $urandom_range(0, 299);
                        if (r < 100) begin
                            if (r[0]) a[ch] = ~a[ch];
                            else b[ch] = ~b[ch];
                        end else if (r == 100) begin
                            a[ch] = ~a[ch];
                            b[ch] = ~b[ch];
                        end
                    end
                end
                for (int sn = 0; sn < SENSOR_W; sn++) begin
                    if ($urandom_range(1, (sn == SNS_BOTTOM) ? bottom_div : 12) == 1) begin
                        s[sn] = ~s[sn];
                    end
                end
                send_tick(a, b, s, $urandom_range(0, 99) < strobe_pct);
            end
        end
    endtask

    initial begin
        sb                     = new();
        i_rst_n                = 1'b0;
        items_if.valid         = 1'b0;
        items_if.action        = ACT_TICK;
        items_if.enc_a         = '0;
        items_if.enc_b         = '0;
        items_if.sensor_levels = '0;
        items_if.ms_strobe     = 1'b0;
        items_if.read_index    = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = REG_CAPTURE_DELAY;
        cfg_if.data            = '0;
        reads_if.ready         = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, run with the reset configuration. The first tick has every A pin
        // high, which counts as an edge on every channel since the previous levels are zero.
        send_tick(6'h3F, 6'h00, 4'h0, 1'b0);
        send_tick(6'h3F, 6'h3F, 4'h0, 1'b1);
        // Both pins of every channel change together, which flags every channel in error.
        send_tick(6'h00, 6'h00, 4'h0, 1'b0);
        send_tick(6'h2A, 6'h00, 4'hF, 1'b1);
        // Top and bottom released together: a top-fall capture and an armed delay.
        send_tick(6'h2A, 6'h15, 4'h0, 1'b1);
        send_tick(6'h2A, 6'h15, 4'h2, 1'b1);
        send_read(RD_COUNT_FIRST);
        send_read(RD_COUNT_LAST);
        send_read(RD_CAPT_FIRST);
        send_read(RD_CAPT_LAST);
        send_read(RD_EVENT_FIRST);
        send_read(RD_EVENT_LAST);
        send_read(RD_LEVELS);
        send_read(RD_ERRORS);
        send_read(RD_UNMAPPED);
        send_read(RD_INDEX_TOP);

        // Zero delay captures on the release tick itself; no channel is reversed.
        reconfigure(8'd0, 8'h00);
        run_phase(280, 25, 20, 50);

        // Long result hold-off while reads keep coming, so that the input stalls.
        reconfigure(8'd1, 8'hFF);
        hold_off = 60;
        for (int k = 0; k < 30; k++) send_read(INDEX_W'($urandom_range(0, 31)));
        run_phase(250, 25, 20, 50);

        // Longest delay: the bottom sensor is held for long stretches and most ticks
        // carry a strobe so that the countdown can run out.
        send_idle_pct = 48;
        recv_idle_pct = 9;
        reconfigure(8'd255, 8'h15);
        run_phase(500, 15, 600, 90);

        reconfigure(8'd3, 8'h2A);
        write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        run_phase(280, 25, 10, 60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        reconfigure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        run_phase(260, 30, 16, 50);

        reconfigure(8'd32, 8'h02);
        run_phase(230, 30, 8, 70);

        items_if.valid = 1'b0;
        for (int k = 0; k < 5000 && sb.expected_reads.size() != 0; k++) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        if (sb.expected_reads.size() != 0) begin
            $error("%0d read results never arrived", sb.expected_reads.size());
            sb.failures++;
        end

        $display("Run covered %0d ticks and %0d checked reads over %0d register settings.",
                 sb.ticks_seen, sb.reads_checked, settings_used);
        $display("Delayed captures fired: %0d; final error bits 0x%02h.",
                 sb.delayed_fired, sb.err_bits);
        if (sb.failures == 0) begin
            $display("[quadrature_counter_with_captures_top] OK");
        end else begin
            $display("[quadrature_counter_with_captures_top] ERROR");
        end
        $finish;
    end

endmodule
